### rtl/magic_framed_crc8_deframer_unit_assert.svh
// Assertion macros for the magic-framed CRC-8 deframer.
// Included by the port-level assertion module; needs nothing else.
`ifndef MAGIC_FRAMED_CRC8_DEFRAMER_UNIT_ASSERT_SVH
`define MAGIC_FRAMED_CRC8_DEFRAMER_UNIT_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define MFCD_ASSERT_NOW(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset
`define MFCD_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/mfcd_pkg.sv
// Shared types, codes and the CRC-8 byte update for the deframer.
// No dependencies; imported by every module of the block.
`default_nettype none

package mfcd_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned POS_W    = 3;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned SEQ_W    = 16;
  localparam int unsigned CFG_AW   = 3;
  localparam int unsigned OUT_TDATA_W = 40;

  // CRC-8, polynomial x^8 + x^2 + x + 1, MSB first
  localparam logic [BYTE_W-1:0] CRC_POLY = 8'h07;

  // Byte positions in a frame
  localparam logic [POS_W-1:0] POS_HUNT    = 3'd0;
  localparam logic [POS_W-1:0] POS_SYNC2   = 3'd1;
  localparam logic [POS_W-1:0] POS_VERSION = 3'd2;
  localparam logic [POS_W-1:0] POS_KIND    = 3'd3;
  localparam logic [POS_W-1:0] POS_SEQ_HI  = 3'd4;
  localparam logic [POS_W-1:0] POS_SEQ_LO  = 3'd5;
  localparam logic [POS_W-1:0] POS_CMD     = 3'd6;
  localparam logic [POS_W-1:0] POS_LAST    = 3'd7;

  // Frame status codes
  localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_VERSION = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_CRC     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_BAD_TYPE    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_BAD_CMD     = 3'd4;

  // Configuration register indexes
  localparam logic [CFG_AW-1:0] REG_SYNC_FIRST   = 3'd0;
  localparam logic [CFG_AW-1:0] REG_SYNC_SECOND  = 3'd1;
  localparam logic [CFG_AW-1:0] REG_VERSION      = 3'd2;
  localparam logic [CFG_AW-1:0] REG_TYPE_CMD     = 3'd3;
  localparam logic [CFG_AW-1:0] REG_TYPE_ACK     = 3'd4;
  localparam logic [CFG_AW-1:0] REG_CMD_ACTIVATE = 3'd5;
  localparam logic [CFG_AW-1:0] REG_CMD_SOS      = 3'd6;
  localparam logic [CFG_AW-1:0] REG_CMD_SAFE     = 3'd7;

  typedef struct packed {
    logic [BYTE_W-1:0] sync_first;
    logic [BYTE_W-1:0] sync_second;
    logic [BYTE_W-1:0] proto_version;
    logic [BYTE_W-1:0] type_code_command;
    logic [BYTE_W-1:0] type_code_ack;
    logic [BYTE_W-1:0] cmd_code_activate;
    logic [BYTE_W-1:0] cmd_code_sos;
    logic [BYTE_W-1:0] cmd_code_safe_zone;
  } cfg_t;

  // Collector to result stage: frame contents plus the closing strobe
  typedef struct packed {
    logic              done;       // last byte taken this cycle
    logic [BYTE_W-1:0] version;
    logic [BYTE_W-1:0] kind;
    logic [BYTE_W-1:0] seq_hi;
    logic [BYTE_W-1:0] seq_lo;
    logic [BYTE_W-1:0] cmd;
    logic [BYTE_W-1:0] crc;        // CRC over version..cmd
    logic [BYTE_W-1:0] crc_rx;     // received CRC byte
  } frm_t;

  function automatic logic [BYTE_W-1:0] crc8_byte(input logic [BYTE_W-1:0] crc_in,
                                                  input logic [BYTE_W-1:0] data);
    logic [BYTE_W-1:0] c;
    c = crc_in ^ data;
    for (int k = 0; k < BYTE_W; k++) begin
      if (c[BYTE_W-1]) begin
        c = {c[BYTE_W-2:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[BYTE_W-2:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

### rtl/mfcd_cfg_regs.sv
// Configuration register file of the deframer (sync bytes, version, codes).
// Depends on mfcd_pkg.
`default_nettype none

module mfcd_cfg_regs
  import mfcd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_wr_en,
  input  wire logic [CFG_AW-1:0] cfg_addr,
  input  wire logic [BYTE_W-1:0] cfg_wdata,
  output cfg_t                   cfg
);

  cfg_t cfg_r, cfg_nxt;

  // Address decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      unique case (cfg_addr)
        REG_SYNC_FIRST:   cfg_nxt.sync_first         = cfg_wdata;
        REG_SYNC_SECOND:  cfg_nxt.sync_second        = cfg_wdata;
        REG_VERSION:      cfg_nxt.proto_version      = cfg_wdata;
        REG_TYPE_CMD:     cfg_nxt.type_code_command  = cfg_wdata;
        REG_TYPE_ACK:     cfg_nxt.type_code_ack      = cfg_wdata;
        REG_CMD_ACTIVATE: cfg_nxt.cmd_code_activate  = cfg_wdata;
        REG_CMD_SOS:      cfg_nxt.cmd_code_sos       = cfg_wdata;
        REG_CMD_SAFE:     cfg_nxt.cmd_code_safe_zone = cfg_wdata;
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

### rtl/mfcd_collector.sv
// Sync hunt, byte position tracking, header byte capture and running CRC.
// Depends on mfcd_pkg.
`default_nettype none

module mfcd_collector
  import mfcd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic              in_ready,
  input  wire logic [BYTE_W-1:0] in_byte,
  input  wire cfg_t              cfg,
  output logic                   at_last,   // next byte closes the frame
  output frm_t                   frm
);

  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [BYTE_W-1:0] crc_r, crc_nxt;
  logic [BYTE_W-1:0] version_r, kind_r, seq_hi_r, seq_lo_r, cmd_r;
  logic              take;

  assign take = in_valid && in_ready;

  // Position state machine; collecting positions step by one
  always_comb begin
    pos_nxt = pos_r;
    if (take) begin
      unique case (pos_r)
        POS_HUNT: begin
          if (in_byte == cfg.sync_first) pos_nxt = POS_SYNC2;
        end
        POS_SYNC2: begin
          // second sync wins; a repeated first sync keeps the hunt at 1
          if (in_byte == cfg.sync_second)     pos_nxt = POS_VERSION;
          else if (in_byte == cfg.sync_first) pos_nxt = POS_SYNC2;
          else                                pos_nxt = POS_HUNT;
        end
        POS_LAST: pos_nxt = POS_HUNT;
        default:  pos_nxt = pos_r + 1'b1;
      endcase
    end
  end

  // Running CRC: restart on the version byte
  always_comb begin
    if (pos_r == POS_VERSION) begin
      crc_nxt = crc8_byte('0, in_byte);
    end else begin
      crc_nxt = crc8_byte(crc_r, in_byte);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= POS_HUNT;
    end else begin
      pos_r <= pos_nxt;
    end
  end

  // Header bytes and CRC, no reset needed
  always_ff @(posedge clk) begin
    if (take) begin
      case (pos_r)
        POS_VERSION: version_r <= in_byte;
        POS_KIND:    kind_r    <= in_byte;
        POS_SEQ_HI:  seq_hi_r  <= in_byte;
        POS_SEQ_LO:  seq_lo_r  <= in_byte;
        POS_CMD:     cmd_r     <= in_byte;
        default:     ;
      endcase
      if (pos_r >= POS_VERSION && pos_r <= POS_CMD) crc_r <= crc_nxt;
    end
  end

  assign at_last = (pos_r == POS_LAST);

  always_comb begin
    frm.done    = take && at_last;
    frm.version = version_r;
    frm.kind    = kind_r;
    frm.seq_hi  = seq_hi_r;
    frm.seq_lo  = seq_lo_r;
    frm.cmd     = cmd_r;
    frm.crc     = crc_r;
    frm.crc_rx  = in_byte;
  end

endmodule

`default_nettype wire

### rtl/mfcd_result.sv
// Frame checks in priority order and the registered result request.
// Depends on mfcd_pkg.
`default_nettype none

module mfcd_result
  import mfcd_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire frm_t                   frm,
  input  wire cfg_t                   cfg,
  input  wire logic                   out_tready,
  output logic                        out_tvalid,
  output logic [OUT_TDATA_W-1:0]      out_tdata
);

  localparam int unsigned PAD_W = OUT_TDATA_W - STATUS_W - 2*BYTE_W - SEQ_W;

  logic                valid_r, valid_nxt;
  logic [STATUS_W-1:0] status_nxt, status_r;
  logic [BYTE_W-1:0]   kind_r, cmd_r;
  logic [SEQ_W-1:0]    seq_r;
  logic                kind_ok, cmd_ok;

  // First failing check sets the status
  always_comb begin
    kind_ok = (frm.kind == cfg.type_code_command) || (frm.kind == cfg.type_code_ack);
    cmd_ok  = (frm.cmd == cfg.cmd_code_activate) || (frm.cmd == cfg.cmd_code_sos) ||
              (frm.cmd == cfg.cmd_code_safe_zone);
    if (frm.version != cfg.proto_version) status_nxt = ST_BAD_VERSION;
    else if (frm.crc_rx != frm.crc)       status_nxt = ST_BAD_CRC;
    else if (!kind_ok)                    status_nxt = ST_BAD_TYPE;
    else if (!cmd_ok)                     status_nxt = ST_BAD_CMD;
    else                                  status_nxt = ST_OK;
  end

  // Valid: set on a new frame, dropped once the request is taken
  always_comb begin
    if (frm.done)        valid_nxt = 1'b1;
    else if (out_tready) valid_nxt = 1'b0;
    else                 valid_nxt = valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (frm.done) begin
      status_r <= status_nxt;
      kind_r   <= frm.kind;
      cmd_r    <= frm.cmd;
      seq_r    <= {frm.seq_hi, frm.seq_lo};
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {{PAD_W{1'b0}}, seq_r, cmd_r, kind_r, status_r};

endmodule

`default_nettype wire

### rtl/magic_framed_crc8_deframer_unit.sv
// A frame's result is shown in the cycle after its last byte is accepted.
// Throughput: one byte per cycle; in_tready drops only while a frame's last
// byte is due and the previous result is still held by the sink.
// Reset (rst_n low at a clock edge): back to sync hunt, config registers to
// zero, no result pending; frame bytes are not cleared.
`default_nettype none

module magic_framed_crc8_deframer_unit
  import mfcd_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // input stream
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [BYTE_W-1:0]      in_tdata,   // [7:0] rx_byte
  // result stream
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // [2:0] frame_status, [10:3] frame_kind, [18:11] command_code,
  // [34:19] sequence_number, [39:35] zero
  output logic [OUT_TDATA_W-1:0]      out_tdata,
  // configuration
  input  wire logic                   cfg_wr_en,
  input  wire logic [CFG_AW-1:0]      cfg_addr,
  input  wire logic [BYTE_W-1:0]      cfg_wdata
);

  cfg_t cfg;
  frm_t frm;
  logic at_last;

  // Stall only a frame-closing byte when the result slot stays full
  assign in_tready = !(at_last && out_tvalid && !out_tready);

  mfcd_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  mfcd_collector u_col (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_byte  (in_tdata),
    .cfg      (cfg),
    .at_last  (at_last),
    .frm      (frm)
  );

  mfcd_result u_res (
    .clk        (clk),
    .rst_n      (rst_n),
    .frm        (frm),
    .cfg        (cfg),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata)
  );

endmodule

`default_nettype wire

### rtl/mfcd_sva.sv
// Port-level assertions for the deframer, bound to the top level.
// Depends on mfcd_pkg and magic_framed_crc8_deframer_unit_assert.svh.
`default_nettype none

`include "magic_framed_crc8_deframer_unit_assert.svh"

module mfcd_sva
  import mfcd_pkg::*;
(
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   in_tvalid,
  input wire logic                   in_tready,
  input wire logic                   out_tvalid,
  input wire logic                   out_tready,
  input wire logic [OUT_TDATA_W-1:0] out_tdata
);

  logic in_take;
  logic pad_zero;
  logic status_ok;

  assign in_take   = in_tvalid && in_tready;
  assign pad_zero  = (out_tdata[OUT_TDATA_W-1:35] == '0);
  assign status_ok = (out_tdata[2:0] <= ST_BAD_CMD);

  // A held result does not change
  `MFCD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "result changed while stalled")

  // Input stalls only behind a held result
  `MFCD_ASSERT_NOW(a_in_stall, clk, rst_n, !in_tready, out_tvalid && !out_tready, "input stalled with result slot free")

  // A fresh result needs a byte accepted the cycle before
  `MFCD_ASSERT_NOW(a_out_cause, clk, rst_n, $rose(out_tvalid), $past(in_take), "result without accepted byte")

  // Status in range and padding zero
  `MFCD_ASSERT_NOW(a_out_fields, clk, rst_n, out_tvalid, status_ok && pad_zero, "bad result encoding")

endmodule

bind magic_framed_crc8_deframer_unit mfcd_sva u_mfcd_sva (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire

### dv/tb_magic_framed_crc8_deframer_unit.sv
`timescale 1ns / 100ps
// Self-checking bench for the CRC-8 frame deframer: framed and noisy byte streams
// with random pacing and a long sink stall, scored against a local frame predictor.
// Depends on mfcd_pkg and magic_framed_crc8_deframer_unit.

module tb_magic_framed_crc8_deframer_unit;
  import mfcd_pkg::*;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [BYTE_W-1:0]   kind;
    logic [BYTE_W-1:0]   cmd;
    logic [SEQ_W-1:0]    seq;
  } frame_result_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [BYTE_W-1:0]      in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_wr_en = 1'b0;
  logic [CFG_AW-1:0]      cfg_addr = '0;
  logic [BYTE_W-1:0]      cfg_wdata = '0;

  // Predictor state: register shadow, frame bytes and hunt/collect position
  logic [7:0][BYTE_W-1:0] cfg_shadow = '0;
  logic [7:0][BYTE_W-1:0] rx_frame = '0;
  logic [POS_W-1:0]       rx_pos = POS_HUNT;
  frame_result_t          pending_frames[$];

  int unsigned bytes_sent = 0;
  int unsigned mismatches = 0;
  int unsigned hold_request = 0;
  bit          send_pace = 1'b1;
  bit          recv_pace = 1'b1;

  magic_framed_crc8_deframer_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // CRC-8 over version..cmd, shifted in serially MSB first
  function automatic logic [BYTE_W-1:0] crc_over(input logic [5*BYTE_W-1:0] body);
    logic [BYTE_W-1:0] c;
    logic              fb;
    c = '0;
    for (int i = 5*BYTE_W-1; i >= 0; i--) begin
      fb = c[BYTE_W-1] ^ body[i];
      c  = {c[BYTE_W-2:0], 1'b0} ^ (fb ? CRC_POLY : '0);
    end
    return c;
  endfunction

  // Advance the predicted deframer by one accepted byte
  function automatic void absorb_byte(input logic [BYTE_W-1:0] b);
    frame_result_t r;
    if (rx_pos == POS_HUNT) begin
      if (b == cfg_shadow[REG_SYNC_FIRST]) begin
        rx_frame[POS_HUNT] = b;
        rx_pos = POS_SYNC2;
      end
    end else if (rx_pos == POS_SYNC2) begin
      // second sync match wins over a repeated first sync byte
      if (b == cfg_shadow[REG_SYNC_SECOND]) begin
        rx_frame[POS_SYNC2] = b;
        rx_pos = POS_VERSION;
      end else if (b == cfg_shadow[REG_SYNC_FIRST]) begin
        rx_frame[POS_HUNT] = b;
      end else begin
        rx_pos = POS_HUNT;
      end
    end else if (rx_pos != POS_LAST) begin
      rx_frame[rx_pos] = b;
      rx_pos = rx_pos + 1'b1;
    end else begin
      rx_frame[POS_LAST] = b;
      rx_pos = POS_HUNT;
      r.kind = rx_frame[POS_KIND];
      r.cmd  = rx_frame[POS_CMD];
      r.seq  = {rx_frame[POS_SEQ_HI], rx_frame[POS_SEQ_LO]};
      // first failing check decides the status
      if (rx_frame[POS_VERSION] != cfg_shadow[REG_VERSION]) begin
        r.status = ST_BAD_VERSION;
      end else if (b != crc_over({rx_frame[POS_VERSION], rx_frame[POS_KIND],
                                  rx_frame[POS_SEQ_HI], rx_frame[POS_SEQ_LO],
                                  rx_frame[POS_CMD]})) begin
        r.status = ST_BAD_CRC;
      end else if (r.kind != cfg_shadow[REG_TYPE_CMD] &&
                   r.kind != cfg_shadow[REG_TYPE_ACK]) begin
        r.status = ST_BAD_TYPE;
      end else if (r.cmd != cfg_shadow[REG_CMD_ACTIVATE] &&
                   r.cmd != cfg_shadow[REG_CMD_SOS] &&
                   r.cmd != cfg_shadow[REG_CMD_SAFE]) begin
        r.status = ST_BAD_CMD;
      end else begin
        r.status = ST_OK;
      end
      pending_frames.push_back(r);
    end
  endfunction

  // One input request: optional idle gap, then hold until accepted
  task automatic send_byte(input logic [BYTE_W-1:0] b);
    int unsigned gap;
    bit          taken;
    gap = send_pace ? $urandom_range(0, 18) : 0;
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      in_tdata  <= BYTE_W'($urandom);
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do begin
      @(negedge clk);
      taken = (in_tready === 1'b1);
      @(posedge clk);
    end while (!taken);
    bytes_sent++;
    absorb_byte(b);
  endtask

  task automatic send_frame(input bit lead, input logic [BYTE_W-1:0] ver, kind,
                            input logic [SEQ_W-1:0] seq, input logic [BYTE_W-1:0] cmd,
                            input logic [BYTE_W-1:0] crc_flip);
    logic [BYTE_W-1:0] crc;
    crc = crc_over({ver, kind, seq, cmd}) ^ crc_flip;
    // a leading extra first-sync byte exercises the restart at position 1
    if (lead) send_byte(cfg_shadow[REG_SYNC_FIRST]);
    send_byte(cfg_shadow[REG_SYNC_FIRST]);
    send_byte(cfg_shadow[REG_SYNC_SECOND]);
    send_byte(ver);
    send_byte(kind);
    send_byte(seq[15:8]);
    send_byte(seq[7:0]);
    send_byte(cmd);
    send_byte(crc);
  endtask

  // Close any half-received frame, then wait for every result to drain
  task automatic settle_block();
    int unsigned       n;
    logic [BYTE_W-1:0] v;
    while (rx_pos != POS_HUNT) begin
      v = BYTE_W'($urandom);
      if (rx_pos != POS_SYNC2 ||
          (v != cfg_shadow[REG_SYNC_FIRST] && v != cfg_shadow[REG_SYNC_SECOND]))
        send_byte(v);
    end
    in_tvalid <= 1'b0;
    for (n = 0; n < 5000 && pending_frames.size() != 0; n++) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_registers(input logic [7:0][BYTE_W-1:0] regs);
    settle_block();
    for (int i = 0; i < 8; i++) begin
      cfg_wr_en <= 1'b1;
      cfg_addr  <= CFG_AW'(i);
      cfg_wdata <= regs[i];
      @(posedge clk);
    end
    cfg_wr_en <= 1'b0;
    cfg_shadow = regs;
  endtask

  // Mostly well-formed frames with random content, the rest line noise
  task automatic run_traffic(input int unsigned n_bytes);
    int unsigned       start, pick;
    logic [BYTE_W-1:0] ver, kind, cmd, flip;
    start = bytes_sent;
    while (bytes_sent - start < n_bytes) begin
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 6)) send_byte(BYTE_W'($urandom));
      end else begin
        ver  = ($urandom_range(0, 99) < 85) ? cfg_shadow[REG_VERSION] : BYTE_W'($urandom);
        pick = $urandom_range(0, 99);
        kind = (pick < 45) ? cfg_shadow[REG_TYPE_CMD] :
               (pick < 85) ? cfg_shadow[REG_TYPE_ACK] : BYTE_W'($urandom);
        pick = $urandom_range(0, 99);
        cmd  = (pick < 30) ? cfg_shadow[REG_CMD_ACTIVATE] :
               (pick < 60) ? cfg_shadow[REG_CMD_SOS] :
               (pick < 85) ? cfg_shadow[REG_CMD_SAFE] : BYTE_W'($urandom);
        flip = ($urandom_range(0, 99) < 85) ? '0 : BYTE_W'($urandom_range(1, 255));
        send_frame($urandom_range(0, 9) == 0, ver, kind, SEQ_W'($urandom), cmd, flip);
      end
    end
  endtask

  // Registers still at reset value: an all-zero frame is valid
  task automatic test_reset_defaults();
    send_frame(1'b0, 8'h00, 8'h00, 16'h0000, 8'h00, 8'h00);
  endtask

  task automatic test_sync_hunt();
    logic [7:0][BYTE_W-1:0] regs;
    regs[REG_SYNC_FIRST]   = 8'hA5;
    regs[REG_SYNC_SECOND]  = 8'h5A;
    regs[REG_VERSION]      = 8'h3C;
    regs[REG_TYPE_CMD]     = 8'hC3;
    regs[REG_TYPE_ACK]     = 8'h81;
    regs[REG_CMD_ACTIVATE] = 8'h11;
    regs[REG_CMD_SOS]      = 8'h7E;
    regs[REG_CMD_SAFE]     = 8'hF0;
    load_registers(regs);
    send_byte(8'h00);
    // broken sync pair drops back to the hunt
    send_byte(8'hA5);
    send_byte(8'h11);
    // repeated first sync byte, then a good acknowledge frame
    send_frame(1'b1, 8'h3C, 8'h81, 16'hFFFF, 8'hF0, 8'h00);
  endtask

  // Check order, and fields carried through on failed frames
  task automatic test_status_priority();
    send_frame(1'b0, 8'h00, 8'h00, 16'h0000, 8'h00, 8'h5A);
    send_frame(1'b0, 8'h3C, 8'hC3, 16'h8001, 8'hFF, 8'h00);
  endtask

  task automatic test_random_frames();
    load_registers({$urandom, $urandom});
    send_pace = 1'b1;
    recv_pace = 1'b1;
    run_traffic(250);
    load_registers({$urandom, $urandom});
    recv_pace = 1'b0;
    run_traffic(250);
  endtask

  // Sink holds off while the source streams back to back
  task automatic test_backpressure();
    load_registers({$urandom, $urandom});
    send_pace    = 1'b0;
    recv_pace    = 1'b0;
    hold_request = 400;
    run_traffic(200);
  endtask

  task automatic test_extreme_registers();
    load_registers({8{8'hFF}});
    send_pace = 1'b0;
    recv_pace = 1'b0;
    run_traffic(150);
    load_registers({8{8'h00}});
    recv_pace = 1'b1;
    run_traffic(150);
  endtask

  // Equal sync bytes, equal type codes and equal command codes
  task automatic test_shared_codes();
    logic [7:0][BYTE_W-1:0] regs;
    regs = {$urandom, $urandom};
    regs[REG_SYNC_SECOND]  = regs[REG_SYNC_FIRST];
    regs[REG_TYPE_ACK]     = regs[REG_TYPE_CMD];
    regs[REG_CMD_SOS]      = regs[REG_CMD_ACTIVATE];
    regs[REG_CMD_SAFE]     = regs[REG_CMD_ACTIVATE];
    load_registers(regs);
    send_pace = 1'b1;
    recv_pace = 1'b1;
    run_traffic(200);
  endtask

  task automatic check_field(input string name, input logic [SEQ_W-1:0] want, got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 40)
        $display("%0t ns: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
    end
  endtask

  // Result sink: per-request stall, long hold on demand, compare on each request
  initial begin : result_checker
    int unsigned            stall, hold;
    bit                     seen;
    logic [OUT_TDATA_W-1:0] word;
    frame_result_t          want;
    stall = 0;
    hold  = 0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_request != 0) begin
        hold = hold_request;
        hold_request = 0;
      end
      if (hold != 0) begin
        out_tready <= 1'b0;
        hold--;
      end else if (stall != 0) begin
        out_tready <= 1'b0;
        stall--;
      end else begin
        out_tready <= 1'b1;
      end
      @(negedge clk);
      seen = (out_tvalid === 1'b1) && out_tready;
      word = out_tdata;
      @(posedge clk);
      if (seen) begin
        stall = recv_pace ? $urandom_range(0, 18) : 0;
        if (pending_frames.size() == 0) begin
          mismatches++;
          if (mismatches <= 40)
            $display("%0t ns: expected no result, got 0x%0h", $time, word);
        end else begin
          want = pending_frames.pop_front();
          check_field("frame_status", SEQ_W'(want.status), SEQ_W'(word[2:0]));
          check_field("frame_kind", SEQ_W'(want.kind), SEQ_W'(word[10:3]));
          check_field("command_code", SEQ_W'(want.cmd), SEQ_W'(word[18:11]));
          check_field("sequence_number", want.seq, word[34:19]);
        end
      end
    end
  end

  initial begin : stimulus
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_sync_hunt();
    test_status_priority();
    test_random_frames();
    test_backpressure();
    test_extreme_registers();
    test_shared_codes();
    settle_block();
    repeat (8) @(posedge clk);
    if (pending_frames.size() != 0) begin
      mismatches++;
      $display("%0t ns: expected %0d more results, got none", $time, pending_frames.size());
    end
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("%0t ns: run timed out", $time);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl
rtl/mfcd_pkg.sv
rtl/mfcd_cfg_regs.sv
rtl/mfcd_collector.sv
rtl/mfcd_result.sv
rtl/magic_framed_crc8_deframer_unit.sv
rtl/mfcd_sva.sv
dv/tb_magic_framed_crc8_deframer_unit.sv
